// ----- rtl/rms_pkg.sv -----
// Shared types and constants of the run merge sorter.
package rms_pkg;

    localparam int VALUE_W     = 32;
    localparam int QUEUE_DEPTH = 4;

    // One classified item as it travels from the front to the back part
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
        logic                      keep;
    } rms_cmd_t;

    // Sequencer states of the back part
    typedef enum logic [4:0] {
        ST_LOAD,
        ST_RUN_INIT,
        ST_INS_KEY_RD,
        ST_INS_KEY,
        ST_INS_CMP_RD,
        ST_INS_CMP,
        ST_MRG_PASS,
        ST_MRG_PAIR,
        ST_MRG_RD_A,
        ST_MRG_LD_A,
        ST_MRG_LD_B,
        ST_MRG_CMP,
        ST_MRG_FILL_A,
        ST_MRG_FILL_B,
        ST_CPY_RD,
        ST_CPY_WR,
        ST_EMIT_RD,
        ST_EMIT
    } rms_state_t;

endpackage

// ----- rtl/rms_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module rms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/rms_front.sv -----
// Front part: accepts items, tracks the fill level and marks kept or dropped items.
module rms_front
    import rms_pkg::*;
#(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [VALUE_W-1:0] value,
    input  logic                      final_item,
    input  logic                      q_full,
    output logic                      push_valid,
    output rms_cmd_t                  push_cmd
);

    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             accept;
    logic             keep;

    // Accept whenever the queue has room
    assign in_ready   = !q_full;
    assign accept     = in_valid && !q_full;
    assign keep       = count_reg < CNT_W'(MAX_ELEMENTS);
    assign push_valid = accept;

    always_comb
    begin
        push_cmd.value = value;
        push_cmd.last  = final_item;
        push_cmd.keep  = keep;
    end

    // Count stored items of the current set; restart after the last item
    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            if (final_item)
            begin
                count_next = '0;
            end
            else if (keep)
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

// ----- rtl/rms_queue.sv -----
// Short queue of classified items between the front and the back part.
module rms_queue
    import rms_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push_valid,
    input  rms_cmd_t push_cmd,
    output logic     full,
    input  logic     pop,
    output rms_cmd_t cmd,
    output logic     cmd_valid
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    rms_cmd_t         entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = count_reg == CNT_W'(QUEUE_DEPTH);
    assign cmd_valid = count_reg != '0;
    assign cmd       = entry_reg[rd_ptr_reg];
    assign do_push   = push_valid && !full;
    assign do_pop    = pop && cmd_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // Store the pushed item
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- rtl/rms_back.sv -----
// Back part: loads the set, sorts runs by insertion, merges runs and emits the result.
module rms_back
    import rms_pkg::*;
#(
    parameter int MAX_ELEMENTS = 64,
    parameter int RUN_LENGTH   = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  rms_cmd_t                  cmd,
    input  logic                      cmd_valid,
    output logic                      cmd_pop,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [VALUE_W-1:0] sorted_value,
    output logic                      final_result
);

    localparam int IDX_W = $clog2(MAX_ELEMENTS);
    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam int RUN_W = $clog2(RUN_LENGTH + 1);
    localparam int POS_W = ((CNT_W > RUN_W) ? CNT_W : RUN_W) + 2;

    rms_state_t state_reg, state_next;

    logic [CNT_W-1:0] n_reg, n_next;
    logic [POS_W-1:0] run_start_reg, run_start_next;
    logic [POS_W-1:0] first_reg, first_next;
    logic [POS_W-1:0] last_reg, last_next;
    logic [POS_W-1:0] i_reg, i_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] width_reg, width_next;
    logic [POS_W-1:0] start_reg, start_next;
    logic [POS_W-1:0] mid_reg, mid_next;
    logic [POS_W-1:0] hi_reg, hi_next;
    logic [POS_W-1:0] a_reg, a_next;
    logic [POS_W-1:0] b_reg, b_next;
    logic [POS_W-1:0] k_reg, k_next;

    logic signed [VALUE_W-1:0] key_reg, key_next;
    logic signed [VALUE_W-1:0] head_a_reg, head_a_next;
    logic signed [VALUE_W-1:0] head_b_reg, head_b_next;

    logic                      out_valid_reg, out_valid_next;
    logic signed [VALUE_W-1:0] out_value_reg, out_value_next;
    logic                      out_final_reg, out_final_next;

    // RAM ports
    logic               st_we;
    logic [IDX_W-1:0]   st_waddr;
    logic [VALUE_W-1:0] st_wdata;
    logic [IDX_W-1:0]   st_raddr;
    logic [VALUE_W-1:0] st_rdata;
    logic               sc_we;
    logic [IDX_W-1:0]   sc_waddr;
    logic [VALUE_W-1:0] sc_wdata;
    logic [IDX_W-1:0]   sc_raddr;
    logic [VALUE_W-1:0] sc_rdata;

    // Derived positions
    logic [POS_W-1:0] n_pos;
    logic [POS_W-1:0] n_last;
    logic [POS_W-1:0] run_end;
    logic [POS_W-1:0] run_after;
    logic [POS_W-1:0] pair_mid;
    logic [POS_W-1:0] pair_end;
    logic [POS_W-1:0] pair_hi;
    logic [POS_W-1:0] pair_step;
    logic             a_ok;
    logic             b_ok;

    assign n_pos     = POS_W'(n_reg);
    assign n_last    = n_pos - POS_W'(1);
    assign run_end   = run_start_reg + POS_W'(RUN_LENGTH - 1);
    assign run_after = run_start_reg + POS_W'(RUN_LENGTH);
    assign pair_step = width_reg << 1;
    assign pair_mid  = start_reg + width_reg - POS_W'(1);
    assign pair_end  = start_reg + pair_step - POS_W'(1);
    assign pair_hi   = (pair_end > n_last) ? n_last : pair_end;
    assign a_ok      = a_reg <= mid_reg;
    assign b_ok      = b_reg <= hi_reg;

    rms_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(MAX_ELEMENTS)
    ) u_element_store (
        .clk  (clk),
        .we   (st_we),
        .waddr(st_waddr),
        .wdata(st_wdata),
        .raddr(st_raddr),
        .rdata(st_rdata)
    );

    rms_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(MAX_ELEMENTS)
    ) u_merge_scratch (
        .clk  (clk),
        .we   (sc_we),
        .waddr(sc_waddr),
        .wdata(sc_wdata),
        .raddr(sc_raddr),
        .rdata(sc_rdata)
    );

    // Sequencer: next state, RAM controls and output register
    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        run_start_next = run_start_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        i_next         = i_reg;
        pos_next       = pos_reg;
        width_next     = width_reg;
        start_next     = start_reg;
        mid_next       = mid_reg;
        hi_next        = hi_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        k_next         = k_reg;
        key_next       = key_reg;
        head_a_next    = head_a_reg;
        head_b_next    = head_b_reg;
        out_value_next = out_value_reg;
        out_final_next = out_final_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd_pop        = 1'b0;
        st_we          = 1'b0;
        st_waddr       = '0;
        st_wdata       = '0;
        st_raddr       = '0;
        sc_we          = 1'b0;
        sc_waddr       = '0;
        sc_wdata       = '0;
        sc_raddr       = '0;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    if (cmd.keep)
                    begin
                        st_we    = 1'b1;
                        st_waddr = n_reg[IDX_W-1:0];
                        st_wdata = cmd.value;
                        n_next   = n_reg + CNT_W'(1);
                    end
                    if (cmd.last)
                    begin
                        run_start_next = '0;
                        state_next     = ST_RUN_INIT;
                    end
                end
            end

            ST_RUN_INIT:
            begin
                first_next = run_start_reg;
                last_next  = (run_end > n_last) ? n_last : run_end;
                i_next     = run_start_reg + POS_W'(1);
                state_next = ST_INS_KEY_RD;
            end

            ST_INS_KEY_RD:
            begin
                if (i_reg > last_reg)
                begin
                    run_start_next = run_after;
                    if (run_after >= n_pos)
                    begin
                        width_next = POS_W'(RUN_LENGTH);
                        state_next = ST_MRG_PASS;
                    end
                    else
                    begin
                        state_next = ST_RUN_INIT;
                    end
                end
                else
                begin
                    st_raddr   = i_reg[IDX_W-1:0];
                    state_next = ST_INS_KEY;
                end
            end

            ST_INS_KEY:
            begin
                key_next   = $signed(st_rdata);
                pos_next   = i_reg;
                state_next = ST_INS_CMP_RD;
            end

            ST_INS_CMP_RD:
            begin
                if (pos_reg > first_reg)
                begin
                    st_raddr   = pos_reg[IDX_W-1:0] - IDX_W'(1);
                    state_next = ST_INS_CMP;
                end
                else
                begin
                    st_we      = 1'b1;
                    st_waddr   = pos_reg[IDX_W-1:0];
                    st_wdata   = key_reg;
                    i_next     = i_reg + POS_W'(1);
                    state_next = ST_INS_KEY_RD;
                end
            end

            ST_INS_CMP:
            begin
                st_we    = 1'b1;
                st_waddr = pos_reg[IDX_W-1:0];
                if ($signed(st_rdata) > key_reg)
                begin
                    // shift the greater element one place right
                    st_wdata   = st_rdata;
                    pos_next   = pos_reg - POS_W'(1);
                    state_next = ST_INS_CMP_RD;
                end
                else
                begin
                    st_wdata   = key_reg;
                    i_next     = i_reg + POS_W'(1);
                    state_next = ST_INS_KEY_RD;
                end
            end

            ST_MRG_PASS:
            begin
                if (width_reg >= n_pos)
                begin
                    k_next     = '0;
                    state_next = ST_EMIT_RD;
                end
                else
                begin
                    start_next = '0;
                    state_next = ST_MRG_PAIR;
                end
            end

            ST_MRG_PAIR:
            begin
                if (start_reg >= n_pos)
                begin
                    width_next = pair_step;
                    state_next = ST_MRG_PASS;
                end
                else if (pair_mid < pair_hi)
                begin
                    mid_next   = pair_mid;
                    hi_next    = pair_hi;
                    a_next     = start_reg;
                    b_next     = pair_mid + POS_W'(1);
                    k_next     = start_reg;
                    state_next = ST_MRG_RD_A;
                end
                else
                begin
                    // lone run at the end: already in place
                    start_next = start_reg + pair_step;
                end
            end

            ST_MRG_RD_A:
            begin
                st_raddr   = a_reg[IDX_W-1:0];
                state_next = ST_MRG_LD_A;
            end

            ST_MRG_LD_A:
            begin
                head_a_next = $signed(st_rdata);
                st_raddr    = b_reg[IDX_W-1:0];
                state_next  = ST_MRG_LD_B;
            end

            ST_MRG_LD_B:
            begin
                head_b_next = $signed(st_rdata);
                state_next  = ST_MRG_CMP;
            end

            ST_MRG_CMP:
            begin
                if (a_ok && (!b_ok || head_a_reg <= head_b_reg))
                begin
                    // take the left head; ties go left
                    sc_we      = 1'b1;
                    sc_waddr   = k_reg[IDX_W-1:0];
                    sc_wdata   = head_a_reg;
                    a_next     = a_reg + POS_W'(1);
                    k_next     = k_reg + POS_W'(1);
                    st_raddr   = a_reg[IDX_W-1:0] + IDX_W'(1);
                    state_next = ST_MRG_FILL_A;
                end
                else if (b_ok)
                begin
                    sc_we      = 1'b1;
                    sc_waddr   = k_reg[IDX_W-1:0];
                    sc_wdata   = head_b_reg;
                    b_next     = b_reg + POS_W'(1);
                    k_next     = k_reg + POS_W'(1);
                    st_raddr   = b_reg[IDX_W-1:0] + IDX_W'(1);
                    state_next = ST_MRG_FILL_B;
                end
                else
                begin
                    k_next     = start_reg;
                    state_next = ST_CPY_RD;
                end
            end

            ST_MRG_FILL_A:
            begin
                head_a_next = $signed(st_rdata);
                state_next  = ST_MRG_CMP;
            end

            ST_MRG_FILL_B:
            begin
                head_b_next = $signed(st_rdata);
                state_next  = ST_MRG_CMP;
            end

            ST_CPY_RD:
            begin
                sc_raddr   = k_reg[IDX_W-1:0];
                state_next = ST_CPY_WR;
            end

            ST_CPY_WR:
            begin
                st_we    = 1'b1;
                st_waddr = k_reg[IDX_W-1:0];
                st_wdata = sc_rdata;
                k_next   = k_reg + POS_W'(1);
                if (k_reg == hi_reg)
                begin
                    start_next = start_reg + pair_step;
                    state_next = ST_MRG_PAIR;
                end
                else
                begin
                    state_next = ST_CPY_RD;
                end
            end

            ST_EMIT_RD:
            begin
                st_raddr   = k_reg[IDX_W-1:0];
                state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                st_raddr = k_reg[IDX_W-1:0];
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = $signed(st_rdata);
                    out_final_next = k_reg == n_last;
                    if (k_reg == n_last)
                    begin
                        n_next     = '0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        k_next     = k_reg + POS_W'(1);
                        state_next = ST_EMIT_RD;
                    end
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working registers and output payload
    always_ff @(posedge clk)
    begin
        run_start_reg <= run_start_next;
        first_reg     <= first_next;
        last_reg      <= last_next;
        i_reg         <= i_next;
        pos_reg       <= pos_next;
        width_reg     <= width_next;
        start_reg     <= start_next;
        mid_reg       <= mid_next;
        hi_reg        <= hi_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        k_reg         <= k_next;
        key_reg       <= key_next;
        head_a_reg    <= head_a_next;
        head_b_reg    <= head_b_next;
        out_value_reg <= out_value_next;
        out_final_reg <= out_final_next;
    end

    assign out_valid    = out_valid_reg;
    assign sorted_value = out_value_reg;
    assign final_result = out_final_reg;

    // Emission never starts on an empty set and stays inside it
    a_emit_in_set: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (n_reg != '0) && (k_reg < n_pos))
        else $error("emit index outside the loaded set");

    // Merge output position tracks the consumed elements of both runs
    a_merge_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MRG_CMP) |-> (k_reg == a_reg + b_reg - mid_reg - POS_W'(1)))
        else $error("merge output position out of step");

    // Insertion position stays between the run start and the current key
    a_ins_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INS_CMP_RD) |-> (pos_reg >= first_reg) && (pos_reg <= i_reg))
        else $error("insertion position outside the run");

    // The loaded count never passes the buffer size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= CNT_W'(MAX_ELEMENTS))
        else $error("loaded count beyond buffer size");

endmodule

// ----- rtl/run_merge_sorter_unit.sv -----
// Run merge sorter: collects a set of signed values, sorts it and streams it back in order.
//
// Items enter a four-deep queue at one per cycle while it has room; a set ends with final_item,
// and items beyond MAX_ELEMENTS are dropped. The back part then sorts the set in one element
// RAM with a single registered read port, which sets the pace: it sorts each RUN_LENGTH run by
// insertion, merges runs pass by pass into the scratch RAM and copies each merged pair back,
// then emits the set in order; the sorting time depends on the input order. A full set of
// 64 values forms two runs of 32. While a set is sorted the queue keeps taking items of the
// next set until it fills; the result stream waits in an output register, so a stalled
// consumer holds up only the emission.
module run_merge_sorter_unit
    import rms_pkg::*;
#(
    parameter int MAX_ELEMENTS = 64,
    parameter int RUN_LENGTH   = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [VALUE_W-1:0] value,
    input  logic                      final_item,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [VALUE_W-1:0] sorted_value,
    output logic                      final_result
);

    rms_cmd_t push_cmd;
    rms_cmd_t cmd;
    logic     push_valid;
    logic     q_full;
    logic     cmd_valid;
    logic     cmd_pop;

    rms_front #(
        .MAX_ELEMENTS(MAX_ELEMENTS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .final_item(final_item),
        .q_full    (q_full),
        .push_valid(push_valid),
        .push_cmd  (push_cmd)
    );

    rms_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_valid(push_valid),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (cmd_pop),
        .cmd       (cmd),
        .cmd_valid (cmd_valid)
    );

    rms_back #(
        .MAX_ELEMENTS(MAX_ELEMENTS),
        .RUN_LENGTH  (RUN_LENGTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cmd_valid   (cmd_valid),
        .cmd_pop     (cmd_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .sorted_value(sorted_value),
        .final_result(final_result)
    );

endmodule
